// File: rtl/core/tkt_pkg.sv
package tkt_pkg;

	localparam int SIZE_W         = 48;
	localparam int TAG_W          = 16;
	localparam int RANK_W         = 4;
	localparam int MAX_RESULTS    = 16;
	localparam int KEEP_COUNT_DEF = 16;

	// s_tdata: size then tag, already whole bytes
	localparam int S_DATA_W = SIZE_W + TAG_W;
	// m_tdata: size, tag, rank, padded to whole bytes
	localparam int M_FIELD_W = SIZE_W + TAG_W + RANK_W;
	localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

	typedef enum logic {
		OP_OFFER  = 1'b0,
		OP_REPORT = 1'b1
	} op_t;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	// per-cycle command shared by all cells
	typedef struct packed {
		logic ins;    // offer is written into the row this cycle
		logic repl;   // row is full, offer replaces the first minimum
		logic shift;  // report: every cell takes its right neighbor
	} cell_ctrl_t;

endpackage

// File: rtl/core/tkt_cell.sv
module tkt_cell #(
	parameter int SLOT_W = 4
) (
	input  logic                clk,
	input  tkt_pkg::cell_ctrl_t ctrl,
	input  logic                valid,
	input  tkt_pkg::entry_t     new_ent,
	input  logic [SLOT_W-1:0]   new_slot,
	input  logic [tkt_pkg::SIZE_W-1:0] min_size,
	input  tkt_pkg::entry_t     left_ent,
	input  logic [SLOT_W-1:0]   left_slot,
	input  logic                left_gt,
	input  logic                left_above,
	input  tkt_pkg::entry_t     right_ent,
	input  logic [SLOT_W-1:0]   right_slot,
	output tkt_pkg::entry_t     ent,
	output logic [SLOT_W-1:0]   slot,
	output logic                gt,
	output logic                above,
	output logic                victim
);
	import tkt_pkg::*;

	entry_t            ent_q;
	logic [SLOT_W-1:0] slot_q;
	logic              at_min;

	// row is kept sorted by size descending, slot ascending
	assign at_min = (ent_q.size == min_size);
	assign gt     = !valid || (new_ent.size > ent_q.size) ||
	                ((new_ent.size == ent_q.size) && (new_slot < slot_q));
	// while full, cells up to and including the first minimum take part in the shift
	assign above  = !ctrl.repl || !at_min;
	assign victim = ctrl.repl && at_min && left_above;

	assign ent  = ent_q;
	assign slot = slot_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			ent_q  <= right_ent;
			slot_q <= right_slot;
		end else if (ctrl.ins) begin
			if (gt && !left_gt) begin
				ent_q  <= new_ent;
				slot_q <= new_slot;
			end else if (left_gt && left_above) begin
				ent_q  <= left_ent;
				slot_q <= left_slot;
			end
		end
	end

endmodule

// File: rtl/core/top_k_largest_tracker.sv
// Top-K largest tracker.
// Input channel s_*: each item is an offer (s_tuser = 0) carrying a size and a tag,
// or a report request (s_tuser = 1). Offers fill the KEEP_COUNT cells until full,
// then replace the lowest-slot entry of minimum size if the offered size is larger.
// The cells form a sorted row (size descending, slot ascending); each offer is
// inserted by shifting the cells between insert point and the replaced one.
// Offers are taken at one per cycle while no report runs.
// A report emits the held entries with nonzero size on m_*, largest first, at most
// 16 of them, with m_tlast on the final one, then empties the row. The row shifts
// left by one cell per emitted item, and the report ends once no item is left;
// the first item is registered in the report state that follows the request.
// s_tready is low while a report runs, up to the edge that takes its last item.
// A stall on m_tready holds the output register and the row, and so the input.
// Reset empties the row (fill count to zero) and drops any pending output item.
module top_k_largest_tracker #(
	parameter int KEEP_COUNT = tkt_pkg::KEEP_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tkt_pkg::S_DATA_W-1:0]  s_tdata,  // item_size, item_tag
	input  logic                          s_tuser,  // operation
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tkt_pkg::M_DATA_W-1:0]  m_tdata,  // out_size, out_tag, out_rank, zero pad
	output logic                          m_tlast   // last_of_report
);
	import tkt_pkg::*;

	localparam int SLOT_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
	localparam int FILL_W = $clog2(KEEP_COUNT + 1);
	localparam int EMIT_W = $clog2(MAX_RESULTS + 1);

	typedef enum logic {
		ST_IDLE,
		ST_REPORT
	} state_t;

	state_t              state_q;
	logic [FILL_W-1:0]   fill_q;
	logic [EMIT_W-1:0]   emit_q;
	logic                m_tvalid_q;
	logic                m_tlast_q;
	entry_t              out_ent_q;
	logic [RANK_W-1:0]   out_rank_q;

	entry_t              ent_w   [KEEP_COUNT+1];
	logic [SLOT_W-1:0]   slot_w  [KEEP_COUNT+1];
	logic                gt_w    [KEEP_COUNT];
	logic                above_w [KEEP_COUNT];
	logic                victim_w[KEEP_COUNT];
	logic                valid_w [KEEP_COUNT];

	entry_t              new_ent;
	logic [SLOT_W-1:0]   new_slot;
	logic [SLOT_W-1:0]   victim_slot;
	logic [SIZE_W-1:0]   min_size;
	logic                full;
	logic                s_acc;
	logic                offer_acc;
	logic                out_free;
	logic                has_next;
	logic                next_last;
	cell_ctrl_t          ctrl;

	assign new_ent.size = s_tdata[SIZE_W-1:0];
	assign new_ent.tag  = s_tdata[S_DATA_W-1:SIZE_W];

	assign full     = (fill_q == FILL_W'(KEEP_COUNT));
	assign min_size = ent_w[KEEP_COUNT-1].size;
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign offer_acc = s_acc && (op_t'(s_tuser) == OP_OFFER);
	assign out_free = !m_tvalid_q || m_tready;

	assign has_next  = (fill_q != '0) && (ent_w[0].size != '0) &&
	                   (emit_q != EMIT_W'(MAX_RESULTS));
	assign next_last = (emit_q == EMIT_W'(MAX_RESULTS - 1)) ||
	                   (fill_q <= FILL_W'(1)) || (ent_w[1].size == '0);

	always_comb begin
		victim_slot = '0;
		for (int i = 0; i < KEEP_COUNT; i++) begin
			if (victim_w[i]) begin
				victim_slot = victim_slot | slot_w[i];
			end
		end
	end

	assign new_slot = full ? victim_slot : fill_q[SLOT_W-1:0];

	assign ctrl.repl  = full;
	assign ctrl.ins   = offer_acc && (!full || (new_ent.size > min_size));
	assign ctrl.shift = (state_q == ST_REPORT) && out_free && has_next;

	assign ent_w[KEEP_COUNT]  = '0;
	assign slot_w[KEEP_COUNT] = '0;

	for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
		logic              lgt;
		logic              labove;
		entry_t            lent;
		logic [SLOT_W-1:0] lslot;

		assign valid_w[i] = (FILL_W'(i) < fill_q);

		if (i == 0) begin : g_head
			assign lgt    = 1'b0;
			assign labove = 1'b1;
			assign lent   = new_ent;
			assign lslot  = new_slot;
		end else begin : g_body
			assign lgt    = gt_w[i-1];
			assign labove = above_w[i-1];
			assign lent   = ent_w[i-1];
			assign lslot  = slot_w[i-1];
		end

		tkt_cell #(
			.SLOT_W(SLOT_W)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.valid     (valid_w[i]),
			.new_ent   (new_ent),
			.new_slot  (new_slot),
			.min_size  (min_size),
			.left_ent  (lent),
			.left_slot (lslot),
			.left_gt   (lgt),
			.left_above(labove),
			.right_ent (ent_w[i+1]),
			.right_slot(slot_w[i+1]),
			.ent       (ent_w[i]),
			.slot      (slot_w[i]),
			.gt        (gt_w[i]),
			.above     (above_w[i]),
			.victim    (victim_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			emit_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
			out_ent_q  <= '0;
			out_rank_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
					end
					if (s_acc) begin
						if (op_t'(s_tuser) == OP_REPORT) begin
							state_q <= ST_REPORT;
							emit_q  <= '0;
						end else if (!full) begin
							fill_q <= fill_q + FILL_W'(1);
						end
					end
				end
				ST_REPORT: begin
					if (out_free) begin
						if (has_next) begin
							m_tvalid_q <= 1'b1;
							m_tlast_q  <= next_last;
							out_ent_q  <= ent_w[0];
							out_rank_q <= emit_q[RANK_W-1:0];
							emit_q     <= emit_q + EMIT_W'(1);
							fill_q     <= fill_q - FILL_W'(1);
						end else begin
							m_tvalid_q <= 1'b0;
							fill_q     <= '0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = {{(M_DATA_W - M_FIELD_W){1'b0}}, out_rank_q, out_ent_q.tag,
	                   out_ent_q.size};

endmodule
